// File: rtl/est_pkg.sv
// Shared types, constants and the key-to-record map for the event storm throttle.
// Depends on nothing; the rtl files other than est_ram refer to it by scoped names.
package est_pkg;

  // Record store size and derived widths
  localparam int RECORDS = 256;
  localparam int KEYS = 256;
  localparam int IDX_W = (RECORDS > 1) ? $clog2(RECORDS) : 1;

  localparam int KEY_W = 8;
  localparam int TIME_W = 32;
  localparam int PASS_W = 16;
  localparam int LIMIT_W = 24;
  localparam int CNT_W = 32;
  localparam int ALU_W = 36;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT = CFG_IDX_W'(1);

  localparam logic [PASS_W-1:0] DEFAULT_PASS = PASS_W'(30);
  localparam logic [LIMIT_W-1:0] DEFAULT_LIMIT = LIMIT_W'(30);
  localparam logic [CNT_W-1:0] INITIAL_THRESHOLD = CNT_W'(10);

  // Result kinds
  localparam logic KIND_PASS = 1'b0;
  localparam logic KIND_NOTICE = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [KEY_W-1:0]  source_key;
    logic [TIME_W-1:0] event_time;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [KEY_W-1:0]  out_key;
    logic [CNT_W-1:0]  suppressed_total;
    logic [TIME_W-1:0] previous_time;
    logic              final_flag;
  } out_item_t;

  // One record of the store
  typedef struct packed {
    logic [TIME_W-1:0] last_seen;
    logic [TIME_W-1:0] last_report;
    logic [PASS_W-1:0] passed;
    logic [CNT_W-1:0]  threshold;
    logic [CNT_W-1:0]  suppressed;
    logic [TIME_W-1:0] stamp;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic             we;
    idx_t             addr;
    logic [REC_W-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             cout;
  } alu_res_t;

  // Record reset: everything back to defaults except the stamp
  function automatic rec_t clear_rec(rec_t r);
    rec_t c;
    c = '0;
    c.threshold = INITIAL_THRESHOLD;
    c.stamp = r.stamp;
    return c;
  endfunction

  typedef idx_t key_map_t [KEYS];

  function automatic key_map_t build_key_map();
    key_map_t m;
    for (int i = 0; i < KEYS; i++) begin
      m[i] = idx_t'(i % RECORDS);
    end
    return m;
  endfunction

  // Key reduced modulo the record count, as a constant lookup
  localparam key_map_t KEY_MAP = build_key_map();

endpackage

// File: rtl/est_ram.sv
// Generic single-port RAM with registered read data.
// Standalone; no package use.
module est_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/est_alu.sv
// Shared add/subtract unit with carry out, used by the sequencer for its compare, increment and multiply steps.
// Depends on est_pkg.
module est_alu (
  input  est_pkg::alu_req_t req,
  output est_pkg::alu_res_t res
);

  logic [est_pkg::ALU_W:0] full;
  logic [est_pkg::ALU_W-1:0] b_op;

  always_comb begin
    b_op = req.sub ? ~req.b : req.b;
    full = {1'b0, req.a} + {1'b0, b_op} + (est_pkg::ALU_W + 1)'(req.sub);
    res.sum = full[est_pkg::ALU_W-1:0];
    res.cout = full[est_pkg::ALU_W];
  end

endmodule

// File: rtl/est_seq.sv
// Sequencer: store clearing sweep, per-event record read-modify-write, result queue.
// Depends on est_pkg; drives est_alu and est_ram through request structs.
module est_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  est_pkg::in_item_t             item,
  input  logic [est_pkg::PASS_W-1:0]    pass_count,
  input  logic [est_pkg::LIMIT_W-1:0]   time_limit,
  output est_pkg::ram_req_t             ram_req,
  input  logic [est_pkg::REC_W-1:0]     ram_rdata,
  output est_pkg::alu_req_t             alu_req,
  input  est_pkg::alu_res_t             alu_res,
  output logic                          result_valid,
  output est_pkg::out_item_t            result
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_GAP1, S_GAP2, S_CMP_PASS, S_INC_PASS,
    S_CMP_TH, S_MUL_TH, S_REP1, S_REP2, S_INC_SUPP, S_WRITE
  } state_t;

  state_t state;
  est_pkg::idx_t clr_cnt;
  est_pkg::idx_t idx;
  logic [est_pkg::KEY_W-1:0] key_r;
  logic [est_pkg::TIME_W-1:0] t_r;
  est_pkg::rec_t rec;
  logic [est_pkg::TIME_W-1:0] diff;
  logic gt;
  logic flushed;
  logic pend_valid;
  est_pkg::out_item_t pend;

  logic accept;
  logic over;
  logic emit;
  est_pkg::out_item_t emit_item;
  est_pkg::rec_t wr_rec;

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  // diff > limit shows as a borrow of limit - diff
  assign over = gt && !alu_res.cout;

  always_comb begin
    wr_rec = rec;
    wr_rec.last_seen = t_r;
    wr_rec.stamp = t_r;
    ram_req.we = 1'b0;
    ram_req.addr = idx;
    ram_req.wdata = est_pkg::REC_W'(wr_rec);
    unique case (state)
      S_CLEAR: begin
        ram_req.we = 1'b1;
        ram_req.addr = clr_cnt;
        ram_req.wdata = est_pkg::REC_W'(est_pkg::clear_rec('0));
      end
      S_IDLE: ram_req.addr = est_pkg::KEY_MAP[item.source_key];
      S_WRITE: ram_req.we = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    alu_req = '0;
    unique case (state)
      S_GAP1: begin
        alu_req.a = est_pkg::ALU_W'(t_r);
        alu_req.b = est_pkg::ALU_W'(rec.last_seen);
        alu_req.sub = 1'b1;
      end
      S_REP1: begin
        alu_req.a = est_pkg::ALU_W'(t_r);
        alu_req.b = est_pkg::ALU_W'(rec.last_report);
        alu_req.sub = 1'b1;
      end
      S_GAP2, S_REP2: begin
        alu_req.a = est_pkg::ALU_W'(time_limit);
        alu_req.b = est_pkg::ALU_W'(diff);
        alu_req.sub = 1'b1;
      end
      S_CMP_PASS: begin
        alu_req.a = est_pkg::ALU_W'(rec.passed);
        alu_req.b = est_pkg::ALU_W'(pass_count);
        alu_req.sub = 1'b1;
      end
      S_INC_PASS: begin
        alu_req.a = est_pkg::ALU_W'(rec.passed);
        alu_req.b = est_pkg::ALU_W'(1);
      end
      S_CMP_TH: begin
        alu_req.a = est_pkg::ALU_W'(rec.suppressed);
        alu_req.b = est_pkg::ALU_W'(rec.threshold);
        alu_req.sub = 1'b1;
      end
      // 10 * th = 8 * th + 2 * th
      S_MUL_TH: begin
        alu_req.a = {1'b0, rec.threshold, 3'b000};
        alu_req.b = {3'b000, rec.threshold, 1'b0};
      end
      S_INC_SUPP: begin
        alu_req.a = est_pkg::ALU_W'(rec.suppressed);
        alu_req.b = est_pkg::ALU_W'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    emit = 1'b0;
    emit_item.kind = est_pkg::KIND_NOTICE;
    emit_item.out_key = key_r;
    emit_item.suppressed_total = rec.suppressed;
    emit_item.previous_time = rec.stamp;
    emit_item.final_flag = 1'b0;
    unique case (state)
      S_GAP2: emit = over && (rec.suppressed != '0);
      S_INC_PASS: begin
        emit = !flushed;
        emit_item.kind = est_pkg::KIND_PASS;
        emit_item.suppressed_total = '0;
      end
      S_MUL_TH: emit = 1'b1;
      S_REP2: emit = over;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      result_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      // one-deep queue: a result leaves once it is known whether another follows
      if (emit) begin
        if (pend_valid) begin
          result_valid <= 1'b1;
          result <= pend;
        end
        pend <= emit_item;
        pend_valid <= 1'b1;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + est_pkg::idx_t'(1);
          if (clr_cnt == est_pkg::idx_t'(est_pkg::RECORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            idx <= est_pkg::KEY_MAP[item.source_key];
            key_r <= item.source_key;
            t_r <= item.event_time;
            flushed <= 1'b0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          rec <= est_pkg::rec_t'(ram_rdata);
          state <= S_GAP1;
        end
        S_GAP1, S_REP1: begin
          diff <= alu_res.sum[est_pkg::TIME_W-1:0];
          gt <= alu_res.cout && (alu_res.sum[est_pkg::TIME_W-1:0] != '0);
          state <= (state == S_GAP1) ? S_GAP2 : S_REP2;
        end
        S_GAP2: begin
          if (over) begin
            rec <= est_pkg::clear_rec(rec);
            flushed <= (rec.suppressed != '0);
          end
          state <= S_CMP_PASS;
        end
        S_CMP_PASS: begin
          state <= alu_res.cout ? S_CMP_TH : S_INC_PASS;
        end
        S_INC_PASS: begin
          rec.passed <= alu_res.sum[est_pkg::PASS_W-1:0];
          rec.last_report <= t_r;
          state <= S_WRITE;
        end
        S_CMP_TH: begin
          state <= alu_res.cout ? S_MUL_TH : S_REP1;
        end
        S_MUL_TH: begin
          rec.threshold <= (alu_res.sum[est_pkg::ALU_W-1:est_pkg::CNT_W] != '0) ? '1 :
                           alu_res.sum[est_pkg::CNT_W-1:0];
          rec.suppressed <= '0;
          rec.last_report <= t_r;
          state <= S_WRITE;
        end
        S_REP2: begin
          if (over) begin
            rec.suppressed <= '0;
            rec.last_report <= t_r;
            state <= S_WRITE;
          end else begin
            state <= S_INC_SUPP;
          end
        end
        S_INC_SUPP: begin
          rec.suppressed <= alu_res.sum[est_pkg::CNT_W-1:0];
          state <= S_WRITE;
        end
        S_WRITE: begin
          result_valid <= pend_valid;
          result <= pend;
          result.final_flag <= 1'b1;
          pend_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !pend_valid)
    else $error("result left queued while idle");

  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_LOAD))
    else $error("accepted event did not start a record read");

  a_final_at_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.final_flag) |-> ($past(state) == S_WRITE))
    else $error("final result sent before the record write");

  a_no_result_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (!result_valid && !pend_valid))
    else $error("result during store clearing");
`endif

endmodule

// File: rtl/event_storm_throttle.sv
// Top level of the event storm throttle: configuration registers and wiring.
// Depends on est_pkg, est_ram, est_alu and est_seq.
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+------------------------------
//  event    | start, busy (start && !busy)     | item: source_key, event_time
//  result   | result_valid, one-cycle strobe   | result: kind, out_key,
//           |                                  |   suppressed_total,
//           |                                  |   previous_time, final_flag
//  config   | cfg_valid, cfg_ready             | cfg_index, cfg_data
//
// After rst the record store is swept back to defaults, one record a cycle,
// with busy high until all RECORDS (256) are cleared. Config transactions are
// taken then too. The next event is accepted only after the record write; the
// shared adder does one compare, increment or multiply step per cycle.
// Each event gives zero to two results, one per cycle; the last one carries
// final_flag. The receiver cannot stall, so results are never held back.
module event_storm_throttle (
  input  logic                              clk,
  input  logic                              rst,
  // event transaction
  input  logic                              start,
  output logic                              busy,
  input  est_pkg::in_item_t                 item,
  // result transaction
  output logic                              result_valid,
  output est_pkg::out_item_t                result,
  // configuration write transaction
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [est_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [est_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [est_pkg::PASS_W-1:0] pass_count;
  logic [est_pkg::LIMIT_W-1:0] time_limit;

  est_pkg::ram_req_t ram_req;
  logic [est_pkg::REC_W-1:0] ram_rdata;
  est_pkg::alu_req_t alu_req;
  est_pkg::alu_res_t alu_res;

  // Registers are always writable; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_count <= est_pkg::DEFAULT_PASS;
      time_limit <= est_pkg::DEFAULT_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        est_pkg::REG_PASS_COUNT: pass_count <= cfg_data[est_pkg::PASS_W-1:0];
        est_pkg::REG_TIME_LIMIT: time_limit <= cfg_data[est_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // One record per source key, all fields in one word
  est_ram #(
    .WIDTH(est_pkg::REC_W),
    .DEPTH(est_pkg::RECORDS)
  ) u_store (
    .clk  (clk),
    .we   (ram_req.we),
    .addr (ram_req.addr),
    .wdata(ram_req.wdata),
    .rdata(ram_rdata)
  );

  est_alu u_alu (
    .req(alu_req),
    .res(alu_res)
  );

  est_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .pass_count  (pass_count),
    .time_limit  (time_limit),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata),
    .alu_req     (alu_req),
    .alu_res     (alu_res),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule

// File: test/testbench.sv
// Self-checking testbench for event_storm_throttle: directed table, then random event phases.
// Depends on rtl/est_pkg.sv and the event_storm_throttle RTL; results are checked against
// a per-record throttle predictor kept in this module.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import est_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  // An event can be absorbed without a result; give it time to retire before
  // touching a register or ending the run.
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASES = 10;
  localparam int EVENTS_PER_PHASE = 110;
  localparam int POOL_KEYS = 3;
  localparam int N_DIRECTED = 26;
  localparam logic [CNT_W-1:0] THRESHOLD_GROWTH = CNT_W'(10);
  // Top of the register index space, well past the last real register
  localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = '1;

  typedef enum logic {ROW_EVENT, ROW_CFG} row_kind_t;

  // One directed row. For config rows, key carries the register index and
  // value the write data. Typed rows carry a hand-written single result.
  typedef struct {
    row_kind_t          kind;
    logic [KEY_W-1:0]   key;
    logic [TIME_W-1:0]  value;
    bit                 typed;
    logic               want_kind;
    logic [CNT_W-1:0]   want_total;
    logic [TIME_W-1:0]  want_prev;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  in_item_t              item;
  logic                  result_valid;
  out_item_t             result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  event_storm_throttle DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // ---------------------------------------------------------------------
  // Throttle predictor: one record per key, plus its own register copies
  // ---------------------------------------------------------------------
  logic [TIME_W-1:0]  seen_at      [RECORDS];
  logic [TIME_W-1:0]  report_at    [RECORDS];
  logic [PASS_W-1:0]  passes_used  [RECORDS];
  logic [CNT_W-1:0]   threshold_of [RECORDS];
  logic [CNT_W-1:0]   held_count   [RECORDS];
  logic [TIME_W-1:0]  stamp_of     [RECORDS];
  logic [PASS_W-1:0]  pass_quota;
  logic [LIMIT_W-1:0] age_limit;

  out_item_t step_results[$];      // results of the event just predicted
  out_item_t expected_results[$];  // results still owed by the block

  int errors = 0;
  int results_checked = 0;
  int notices_seen = 0;
  int events_sent = 0;
  int cfg_writes = 0;
  int double_events = 0;
  int cycles = 0;

  // Record reset: everything back to defaults except the stamp
  function automatic void clear_record(int rec);
    seen_at[rec] = '0;
    report_at[rec] = '0;
    passes_used[rec] = '0;
    threshold_of[rec] = INITIAL_THRESHOLD;
    held_count[rec] = '0;
  endfunction

  // Elapsed time only counts when time moved forward
  function automatic bit gap_exceeds(logic [TIME_W-1:0] now, logic [TIME_W-1:0] then);
    return (now > then) && ((now - then) > TIME_W'(age_limit));
  endfunction

  function automatic void add_result(logic kind, logic [KEY_W-1:0] key,
                                     logic [CNT_W-1:0] total, logic [TIME_W-1:0] prev);
    out_item_t r;
    r.kind = kind;
    r.out_key = key;
    r.suppressed_total = total;
    r.previous_time = prev;
    r.final_flag = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void predict_event(in_item_t ev);
    int rec;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] prev;
    bit flushed;
    rec = int'(ev.source_key) % RECORDS;
    t = ev.event_time;
    prev = stamp_of[rec];
    flushed = 1'b0;
    step_results.delete();

    // Idle gap: flush whatever is pending and start the record over
    if (gap_exceeds(t, seen_at[rec])) begin
      if (held_count[rec] != '0) begin
        add_result(KIND_NOTICE, ev.source_key, held_count[rec], prev);
        flushed = 1'b1;
      end
      clear_record(rec);
    end

    if (passes_used[rec] < pass_quota) begin
      passes_used[rec] = passes_used[rec] + PASS_W'(1);
      report_at[rec] = t;
      // a flush notice stands in for the pass-through
      if (!flushed) add_result(KIND_PASS, ev.source_key, '0, prev);
    end else if (held_count[rec] >= threshold_of[rec]) begin
      // threshold grows tenfold, saturating at all ones
      if (threshold_of[rec] > CNT_W'('1) / THRESHOLD_GROWTH) threshold_of[rec] = '1;
      else threshold_of[rec] = threshold_of[rec] * THRESHOLD_GROWTH;
      add_result(KIND_NOTICE, ev.source_key, held_count[rec], prev);
      report_at[rec] = t;
      held_count[rec] = '0;
    end else if (gap_exceeds(t, report_at[rec])) begin
      add_result(KIND_NOTICE, ev.source_key, held_count[rec], prev);
      report_at[rec] = t;
      held_count[rec] = '0;
    end else begin
      held_count[rec] = held_count[rec] + CNT_W'(1);
    end

    seen_at[rec] = t;
    stamp_of[rec] = t;
    if (step_results.size() > 0) step_results[step_results.size() - 1].final_flag = 1'b1;
    if (step_results.size() > 1) double_events++;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Offer one event; start stays high on return so the next one can follow
  // without a bubble.
  task automatic send_event(input in_item_t ev, input int gap, input bit typed,
                            input out_item_t want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= ev;
    do @(posedge clk); while (busy);
    predict_event(ev);
    if (typed) begin
      expected_results.push_back(want);
    end else begin
      foreach (step_results[i]) expected_results.push_back(step_results[i]);
    end
    events_sent++;
  endtask

  // Register writes only with the pipe drained and the block at rest
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_PASS_COUNT) pass_quota = data[PASS_W-1:0];
    else if (idx == REG_TIME_LIMIT) age_limit = data[LIMIT_W-1:0];
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------
  // Directed table: reset defaults, time running backwards, boundary gaps,
  // zero pass count with a zero limit (flush followed by a second notice),
  // flush that swallows the pass-through, an out-of-range register index,
  // and both registers at their maxima with extreme keys and times.
  // ---------------------------------------------------------------------
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_EVENT, 8'd0,   32'd0,          1'b1, KIND_PASS,   32'd0, 32'd0},
    '{ROW_EVENT, 8'd255, 32'hFFFF_FFFF,  1'b1, KIND_PASS,   32'd0, 32'd0},
    '{ROW_EVENT, 8'd255, 32'd0,          1'b1, KIND_PASS,   32'd0, 32'hFFFF_FFFF},
    '{ROW_EVENT, 8'd0,   32'd30,         1'b1, KIND_PASS,   32'd0, 32'd0},
    '{ROW_EVENT, 8'd0,   32'd61,         1'b1, KIND_PASS,   32'd0, 32'd30},
    '{ROW_CFG,   8'(REG_LAST_INDEX), 32'h00FF_FFFF, 1'b0, KIND_PASS, 32'd0, 32'd0},
    '{ROW_CFG,   8'(REG_PASS_COUNT), 32'd0,         1'b0, KIND_PASS, 32'd0, 32'd0},
    '{ROW_CFG,   8'(REG_TIME_LIMIT), 32'd0,         1'b0, KIND_PASS, 32'd0, 32'd0},
    '{ROW_EVENT, 8'd1,   32'd5,          1'b1, KIND_NOTICE, 32'd0, 32'd0},
    '{ROW_EVENT, 8'd1,   32'd5,          1'b0, KIND_PASS,   32'd0, 32'd0},
    '{ROW_EVENT, 8'd1,   32'd5,          1'b0, KIND_PASS,   32'd0, 32'd0},
    '{ROW_EVENT, 8'd1,   32'd5,          1'b0, KIND_PASS,   32'd0, 32'd0},
    '{ROW_EVENT, 8'd1,   32'd6,          1'b0, KIND_PASS,   32'd0, 32'd0},
    '{ROW_CFG,   8'(REG_PASS_COUNT), 32'd2,         1'b0, KIND_PASS, 32'd0, 32'd0},
    '{ROW_CFG,   8'(REG_TIME_LIMIT), 32'd3,         1'b0, KIND_PASS, 32'd0, 32'd0},
    '{ROW_EVENT, 8'd2,   32'd100,        1'b0, KIND_PASS,   32'd0, 32'd0},
    '{ROW_EVENT, 8'd2,   32'd100,        1'b0, KIND_PASS,   32'd0, 32'd0},
    '{ROW_EVENT, 8'd2,   32'd100,        1'b0, KIND_PASS,   32'd0, 32'd0},
    '{ROW_EVENT, 8'd2,   32'd101,        1'b0, KIND_PASS,   32'd0, 32'd0},
    '{ROW_EVENT, 8'd2,   32'd110,        1'b0, KIND_PASS,   32'd0, 32'd0},
    '{ROW_CFG,   8'(REG_PASS_COUNT), 32'h00FF_FFFF, 1'b0, KIND_PASS, 32'd0, 32'd0},
    '{ROW_CFG,   8'(REG_TIME_LIMIT), 32'h00FF_FFFF, 1'b0, KIND_PASS, 32'd0, 32'd0},
    '{ROW_EVENT, 8'd170, 32'hAAAA_AAAA,  1'b0, KIND_PASS,   32'd0, 32'd0},
    '{ROW_EVENT, 8'd85,  32'h5555_5555,  1'b0, KIND_PASS,   32'd0, 32'd0},
    '{ROW_EVENT, 8'd255, 32'hFFFF_FFFF,  1'b0, KIND_PASS,   32'd0, 32'd0},
    '{ROW_EVENT, 8'd0,   32'd0,          1'b0, KIND_PASS,   32'd0, 32'd0}
  };

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: the receiver cannot stall, so every strobe is a
  // transaction and must match the oldest expectation.
  // ---------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: kind %0d key %0d", result.kind, result.out_key);
        errors++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (want.kind == KIND_NOTICE) notices_seen++;
        check_field("kind", 32'(want.kind), 32'(result.kind));
        check_field("out_key", 32'(want.out_key), 32'(result.out_key));
        check_field("suppressed_total", want.suppressed_total, result.suppressed_total);
        check_field("previous_time", want.previous_time, result.previous_time);
        check_field("final_flag", 32'(want.final_flag), 32'(result.final_flag));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    in_item_t ev;
    out_item_t want;
    logic [KEY_W-1:0] pool [POOL_KEYS];
    logic [TIME_W-1:0] clock_of [KEYS];
    logic [PASS_W-1:0] pass_now;
    logic [LIMIT_W-1:0] limit_now;
    bit steady;
    int roll;

    // predictor starts from the reset state
    for (int r = 0; r < RECORDS; r++) begin
      clear_record(r);
      stamp_of[r] = '0;
    end
    pass_quota = DEFAULT_PASS;
    age_limit = DEFAULT_LIMIT;

    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // the record sweep after reset shows up as busy; send_event waits it out

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_reg(directed_rows[i].key[CFG_IDX_W-1:0], directed_rows[i].value[CFG_DATA_W-1:0]);
      end else begin
        ev.source_key = directed_rows[i].key;
        ev.event_time = directed_rows[i].value;
        want.kind = directed_rows[i].want_kind;
        want.out_key = directed_rows[i].key;
        want.suppressed_total = directed_rows[i].want_total;
        want.previous_time = directed_rows[i].want_prev;
        want.final_flag = 1'b1;
        send_event(ev, pick_gap(), directed_rows[i].typed, want);
      end
    end

    // Random phases: each picks a setting, a small pool of hot keys and
    // mostly repeated or slowly advancing times, so records walk through
    // pass, suppress, threshold and age reports, with flush gaps, time
    // going backwards and wild times mixed in.
    foreach (clock_of[k]) clock_of[k] = TIME_W'($urandom_range(0, 1000));
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 2) pass_now = '1;
      else if (phase == 7) pass_now = PASS_W'($urandom);
      else pass_now = PASS_W'($urandom_range(0, 4));
      if (phase == 3) limit_now = '1;
      else if (phase == 5) limit_now = '0;
      else if (phase == 8) limit_now = LIMIT_W'($urandom);
      else limit_now = LIMIT_W'($urandom_range(1, 12));
      // upper data bits of the pass count write must be dropped
      write_reg(REG_PASS_COUNT, {8'($urandom), pass_now});
      write_reg(REG_TIME_LIMIT, limit_now);
      if (phase == 6) begin
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_TIME_LIMIT) + 1, int'(REG_LAST_INDEX))),
                  CFG_DATA_W'($urandom));
      end
      foreach (pool[k]) pool[k] = KEY_W'($urandom);
      steady = (phase % 3 == 1);

      for (int n = 0; n < EVENTS_PER_PHASE; n++) begin
        if ($urandom_range(0, 3) != 0) ev.source_key = pool[$urandom_range(0, POOL_KEYS - 1)];
        else ev.source_key = KEY_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          // same second: builds up suppressed counts
        end else if (roll < 80) begin
          clock_of[ev.source_key] += TIME_W'($urandom_range(1, 3));
        end else if (roll < 90) begin
          clock_of[ev.source_key] += TIME_W'(limit_now) + TIME_W'($urandom_range(1, 6));
        end else if (roll < 95) begin
          clock_of[ev.source_key] -= TIME_W'($urandom_range(1, 50));
        end else begin
          clock_of[ev.source_key] = TIME_W'($urandom);
        end
        ev.event_time = clock_of[ev.source_key];
        send_event(ev, steady ? 0 : pick_gap(), 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end

    $display("Run covered %0d events and %0d register writes over %0d setting phases.",
             events_sent, cfg_writes, PHASES);
    $display("%0d results checked: %0d notices, %0d events with two results, %0d errors.",
             results_checked, notices_seen, double_events, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
